@@ rtl/rcd_pkg.sv @@
// rcd_pkg: shared types and constants of the run-length coefficient dequantizer
// holds the zigzag-to-raster map, word codes and the dequantizer request type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rcd_pkg;

  // block geometry
  localparam int NUM_COEF = 64;
  localparam logic [5:0] LAST_POS = 6'd63;

  // input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_WORD = 1'b1;

  // padding / end-of-block word
  localparam logic [15:0] PAD_WORD = 16'hFE00;

  // coefficient clamp limits
  localparam int VAL_MAX = 16383;
  localparam int VAL_MIN = -16384;

  typedef logic signed [9:0]  level_t;
  typedef logic signed [14:0] coef_t;

  // request into the dequant unit, one cycle wide
  typedef struct packed {
    logic       vld;
    logic       dc;
    logic [5:0] scale;
    level_t     level;
  } dq_req_t;

  // zigzag slot to raster position
  localparam logic [5:0] ZZ_TO_RASTER [NUM_COEF] = '{
    6'd0,  6'd8,  6'd1,  6'd2,  6'd9,  6'd16, 6'd24, 6'd17,
    6'd10, 6'd3,  6'd4,  6'd11, 6'd18, 6'd25, 6'd32, 6'd40,
    6'd33, 6'd26, 6'd19, 6'd12, 6'd5,  6'd6,  6'd13, 6'd20,
    6'd27, 6'd34, 6'd41, 6'd48, 6'd56, 6'd49, 6'd42, 6'd35,
    6'd28, 6'd21, 6'd14, 6'd7,  6'd15, 6'd22, 6'd29, 6'd36,
    6'd43, 6'd50, 6'd57, 6'd58, 6'd51, 6'd44, 6'd37, 6'd30,
    6'd23, 6'd31, 6'd38, 6'd45, 6'd52, 6'd59, 6'd60, 6'd53,
    6'd46, 6'd39, 6'd47, 6'd54, 6'd61, 6'd62, 6'd55, 6'd63
  };

endpackage

`default_nettype wire

@@ rtl/rcd_qtable.sv @@
// rcd_qtable: 64 x 8 quant table memory, one write and one registered read port
// depends on nothing outside this file
`timescale 1ns / 1ps
`default_nettype none

module rcd_qtable (
  input  wire logic       clk_i,
  input  wire logic       wr_en_i,
  input  wire logic [5:0] wr_addr_i,
  input  wire logic [7:0] wr_data_i,
  input  wire logic [5:0] rd_addr_i,
  output logic      [7:0] rd_data_o
);

  logic [7:0] mem_q [64];
  logic [7:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/rcd_coef_store.sv @@
// rcd_coef_store: 64-entry coefficient memory with per-entry valid flags
// entries not written since the last block clear read as zero; uses rcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rcd_coef_store (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire logic [5:0]    wr_addr_i,
  input  wire rcd_pkg::coef_t wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [5:0]    rd_addr_i,
  input  wire logic          clr_i,
  output rcd_pkg::coef_t     rd_data_o
);

  import rcd_pkg::*;

  coef_t       mem_q [NUM_COEF];
  logic [63:0] valid_q;
  coef_t       rd_data_q;
  logic        hit_q;

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // valid flags, cleared all at once at the end of a block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (rd_en_i) begin
        hit_q <= valid_q[rd_addr_i];
      end
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = hit_q ? rd_data_q : '0;

endmodule

`default_nettype wire

@@ rtl/rcd_dequant.sv @@
// rcd_dequant: two-stage dequantizer, quant factor then level product, then rounding and clamp
// uses rcd_pkg for the request type and clamp limits
`timescale 1ns / 1ps
`default_nettype none

module rcd_dequant (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rcd_pkg::dq_req_t req_i,
  input  wire logic [7:0]       qt_i,
  output logic                  vld_o,
  output rcd_pkg::coef_t        value_o
);

  import rcd_pkg::*;

  // stage 1: effective quant factor
  logic         vld1_q;
  logic         dc1_q;
  level_t       level1_q;
  logic [13:0]  q1_q;

  // stage 2: level times factor
  logic         vld2_q;
  logic         dc2_q;
  logic         qz2_q;
  level_t       level2_q;
  logic signed [23:0] prod2_q;

  logic [13:0]        q_d;
  logic signed [23:0] prod_d;
  logic signed [23:0] shifted;
  logic signed [28:0] scaled;
  logic signed [28:0] rounded;
  coef_t              value;

  // dc uses the table entry alone, ac scales it by the block scale
  always_comb begin
    if (req_i.dc) begin
      q_d = {6'd0, qt_i};
    end else begin
      q_d = 14'(req_i.scale) * 14'(qt_i);
    end
  end

  assign prod_d = 24'(level1_q) * 24'($signed({1'b0, q1_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= req_i.vld;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dc1_q    <= req_i.dc;
    level1_q <= req_i.level;
    q1_q     <= q_d;
    dc2_q    <= dc1_q;
    qz2_q    <= (q1_q == '0);
    level2_q <= level1_q;
    prod2_q  <= prod_d;
  end

  // floor divide by 8 for ac, times 16, sign-dependent rounding, clamp; a zero factor gives level times 32
  always_comb begin
    shifted = dc2_q ? prod2_q : (prod2_q >>> 3);
    scaled  = $signed({shifted[23], shifted, 4'b0000});
    if (level2_q < 0) begin
      rounded = scaled + 29'sd8;
    end else if (level2_q > 0) begin
      rounded = scaled - 29'sd8;
    end else begin
      rounded = scaled;
    end
    if (qz2_q) begin
      value = {level2_q, 5'b00000};
    end else if (rounded > 29'(VAL_MAX)) begin
      value = 15'(VAL_MAX);
    end else if (rounded < 29'(VAL_MIN)) begin
      value = 15'(VAL_MIN);
    end else begin
      value = rounded[14:0];
    end
  end

  assign vld_o   = vld2_q;
  assign value_o = value;

endmodule

`default_nettype wire

@@ rtl/rle_coefficient_dequantizer.sv @@
// rle_coefficient_dequantizer: top level, word sequencer around the quant table,
// the dequant unit and the coefficient store; uses rcd_pkg and the rcd_* modules
//
// A coefficient word passes through the quant table read, the two multiply
// stages of the dequant unit and the coefficient store write. A padding word
// at block start is dropped. When a block completes, the store is read out in
// raster order, one result per cycle for all 64 positions, paced by the single
// store read port; busy stays high during the readout, and the last result
// shows in the same cycle that busy falls. Results cannot be held off by the
// receiver. No clearing pass follows reset: store entries carry valid flags
// that reset and every block readout clear.
`timescale 1ns / 1ps
`default_nettype none

module rle_coefficient_dequantizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command_i,
  input  wire logic [5:0]  table_index_i,
  input  wire logic [7:0]  table_value_i,
  input  wire logic [15:0] rle_word_i,
  output logic             result_valid_o,
  output logic [5:0]       coeff_position_o,
  output rcd_pkg::coef_t   coeff_value_o,
  output logic             block_last_o
);

  import rcd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_EMIT
  } state_e;

  state_e     state_q;
  logic [6:0] idx_q;
  logic [5:0] scale_q;
  level_t     level_q;
  logic       dc_q;
  logic       go_q;
  logic [5:0] k_q;
  logic [5:0] cnt_q;
  logic       out_vld_q;
  logic [5:0] pos_q;

  logic       accept;
  logic       is_pad;
  logic [6:0] slot_sum;
  logic [5:0] qt_rd_addr;
  dq_req_t    dq_req;
  logic [7:0] qt_data;
  logic       dq_vld;
  coef_t      dq_value;
  logic       store_wr;
  logic       store_rd;
  logic       store_clr;

  // item decode
  assign accept   = start && !busy;
  assign is_pad   = (rle_word_i == PAD_WORD);
  assign slot_sum = idx_q + {1'b0, rle_word_i[15:10]};

  // table read address is the zigzag slot of the word being accepted
  assign qt_rd_addr = (idx_q == '0) ? 6'd0 : slot_sum[5:0];

  assign dq_req.vld   = go_q;
  assign dq_req.dc    = dc_q;
  assign dq_req.scale = scale_q;
  assign dq_req.level = level_q;

  assign store_wr  = (state_q == S_CALC) && dq_vld;
  assign store_rd  = (state_q == S_EMIT);
  assign store_clr = store_rd && (cnt_q == LAST_POS);

  rcd_qtable u_qtable (
    .clk_i     (clk_i),
    .wr_en_i   (accept && (command_i == CMD_LOAD)),
    .wr_addr_i (table_index_i),
    .wr_data_i (table_value_i),
    .rd_addr_i (qt_rd_addr),
    .rd_data_o (qt_data)
  );

  rcd_dequant u_dequant (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (dq_req),
    .qt_i    (qt_data),
    .vld_o   (dq_vld),
    .value_o (dq_value)
  );

  rcd_coef_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (store_wr),
    .wr_addr_i (ZZ_TO_RASTER[k_q]),
    .wr_data_i (dq_value),
    .rd_en_i   (store_rd),
    .rd_addr_i (cnt_q),
    .clr_i     (store_clr),
    .rd_data_o (coeff_value_o)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      scale_q   <= '0;
      level_q   <= '0;
      dc_q      <= 1'b0;
      go_q      <= 1'b0;
      k_q       <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      pos_q     <= '0;
    end else begin
      go_q      <= 1'b0;
      out_vld_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept && (command_i == CMD_WORD)) begin
            if (idx_q == '0) begin
              // dc word sets the block scale; padding is dropped
              if (!is_pad) begin
                scale_q <= rle_word_i[15:10];
                level_q <= rle_word_i[9:0];
                dc_q    <= 1'b1;
                k_q     <= '0;
                go_q    <= 1'b1;
                state_q <= S_CALC;
              end
            end else if (is_pad || slot_sum[6]) begin
              // end of block, or run past the last slot
              cnt_q   <= '0;
              state_q <= S_EMIT;
            end else begin
              level_q <= rle_word_i[9:0];
              dc_q    <= 1'b0;
              k_q     <= slot_sum[5:0];
              go_q    <= 1'b1;
              state_q <= S_CALC;
            end
          end
        end
        S_CALC: begin
          if (dq_vld) begin
            idx_q <= {1'b0, k_q} + 7'd1;
            if (k_q == LAST_POS) begin
              cnt_q   <= '0;
              state_q <= S_EMIT;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          out_vld_q <= 1'b1;
          pos_q     <= cnt_q;
          cnt_q     <= cnt_q + 6'd1;
          if (cnt_q == LAST_POS) begin
            idx_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy             = (state_q != S_IDLE);
  assign result_valid_o   = out_vld_q;
  assign coeff_position_o = pos_q;
  assign block_last_o     = out_vld_q && (pos_q == LAST_POS);

endmodule

`default_nettype wire

@@ rtl/rcd_checker.sv @@
// rcd_checker: port-level checks on the result readout of the dequantizer
// bound to rle_coefficient_dequantizer; uses rcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rcd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       busy,
  input wire logic       result_valid_o,
  input wire logic [5:0] coeff_position_o,
  input wire logic       block_last_o
);

  import rcd_pkg::*;

  // a readout starts at raster position zero
  a_first_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_o) |-> coeff_position_o == 6'd0)
    else $error("readout did not start at position zero");

  // positions run without gaps until the last item of the block
  a_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !block_last_o |=>
      result_valid_o && coeff_position_o == $past(coeff_position_o) + 6'd1)
    else $error("readout gap or position out of order");

  // last marker only on position 63 of a valid item
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_last_o |-> result_valid_o && coeff_position_o == LAST_POS)
    else $error("block_last on wrong item");

  // no new item is taken while a readout is still running
  a_busy_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !block_last_o |-> busy)
    else $error("block not busy during readout");

endmodule

bind rle_coefficient_dequantizer rcd_checker u_rcd_checker (.*);

`default_nettype wire

@@ sim/tb_top.sv @@
// tb_top: self-checking testbench for rle_coefficient_dequantizer
// drives table loads and run-length words, predicts every emitted coefficient
// depends on rcd_pkg and rle_coefficient_dequantizer from rtl/
`timescale 1ns / 1ps

module tb_top;
  import rcd_pkg::*;

  // expected coefficient of an emitted block
  typedef struct packed {
    logic [5:0] pos;
    coef_t      value;
    logic       last;
  } coef_result_t;

  // one row of the directed stimulus, typed_val overrides the predicted coefficient
  typedef struct packed {
    logic        cmd;
    logic [5:0]  idx;
    logic [7:0]  val;
    logic [15:0] word;
    logic        typed;
    coef_t       typed_val;
  } stim_row_t;

  localparam int NUM_DIRECTED = 22;
  localparam int NUM_RANDOM   = 450;

  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // padding word at block start is ignored
    '{CMD_WORD, 6'd0,  8'd0,   PAD_WORD, 1'b0, 15'sd0},
    // zero dc quant factor, dc level at its positive extreme
    '{CMD_LOAD, 6'd0,  8'd0,   16'h0000, 1'b0, 15'sd0},
    '{CMD_WORD, 6'd0,  8'd0,   16'hFDFF, 1'b1, 15'sd16352},
    // largest ac factor with the most negative level clamps low
    '{CMD_LOAD, 6'd1,  8'd255, 16'h0000, 1'b0, 15'sd0},
    '{CMD_WORD, 6'd0,  8'd0,   16'h0200, 1'b1, -15'sd16384},
    // zero level gets no rounding offset
    '{CMD_LOAD, 6'd2,  8'd1,   16'h0000, 1'b0, 15'sd0},
    '{CMD_WORD, 6'd0,  8'd0,   16'h0000, 1'b1, 15'sd0},
    // small positive level under a large factor clamps high
    '{CMD_LOAD, 6'd3,  8'd255, 16'h0000, 1'b0, 15'sd0},
    '{CMD_WORD, 6'd0,  8'd0,   16'h0001, 1'b1, 15'sd16383},
    // end of block fills with zeros and emits
    '{CMD_WORD, 6'd0,  8'd0,   PAD_WORD, 1'b0, 15'sd0},
    // dc at scale zero still uses the table
    '{CMD_LOAD, 6'd0,  8'd255, 16'h0000, 1'b0, 15'sd0},
    '{CMD_WORD, 6'd0,  8'd0,   16'h0200, 1'b1, -15'sd16384},
    // ac at scale zero takes level times 32
    '{CMD_LOAD, 6'd6,  8'd200, 16'h0000, 1'b0, 15'sd0},
    '{CMD_WORD, 6'd0,  8'd0,   16'h17FF, 1'b1, -15'sd32},
    // run past the end drops the level and emits
    '{CMD_WORD, 6'd0,  8'd0,   16'hFD55, 1'b0, 15'sd0},
    // dc with scale one, rounding toward zero
    '{CMD_WORD, 6'd0,  8'd0,   16'h0401, 1'b1, 15'sd4072},
    // run landing on the last slot fills the block exactly
    '{CMD_LOAD, 6'd63, 8'd8,   16'h0000, 1'b0, 15'sd0},
    '{CMD_WORD, 6'd0,  8'd0,   16'hFBFD, 1'b1, -15'sd40},
    // load in the middle of a block applies to later words
    '{CMD_WORD, 6'd0,  8'd0,   16'h0800, 1'b1, 15'sd0},
    '{CMD_LOAD, 6'd1,  8'd4,   16'h0000, 1'b0, 15'sd0},
    '{CMD_WORD, 6'd0,  8'd0,   16'h0005, 1'b1, 15'sd72},
    '{CMD_WORD, 6'd0,  8'd0,   PAD_WORD, 1'b0, 15'sd0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        command_i;
  logic [5:0]  table_index_i;
  logic [7:0]  table_value_i;
  logic [15:0] rle_word_i;
  logic        result_valid_o;
  logic [5:0]  coeff_position_o;
  coef_t       coeff_value_o;
  logic        block_last_o;

  // predictor state
  logic [7:0]   qtab [NUM_COEF];
  bit           qtab_written [NUM_COEF];
  coef_t        coef_store [NUM_COEF];
  int           zz_idx;
  logic [5:0]   blk_scale;
  coef_result_t coef_expect_q [$];

  int mismatch_count;
  int burst_left;

  rle_coefficient_dequantizer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .table_index_i    (table_index_i),
    .table_value_i    (table_value_i),
    .rle_word_i       (rle_word_i),
    .result_valid_o   (result_valid_o),
    .coeff_position_o (coeff_position_o),
    .coeff_value_o    (coeff_value_o),
    .block_last_o     (block_last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // scale, round and clamp one coefficient
  function automatic coef_t dequant_coef(input int lvl, input int q, input int prod);
    int v;
    if (q == 0) begin
      v = lvl * 32;
    end else begin
      v = prod * 16;
      if (lvl < 0) v += 8;
      else if (lvl > 0) v -= 8;
    end
    if (v < VAL_MIN) v = VAL_MIN;
    if (v > VAL_MAX) v = VAL_MAX;
    return coef_t'(v);
  endfunction

  // queue the whole block in raster order and clear the store
  task automatic emit_block();
    for (int i = 0; i < NUM_COEF; i++) begin
      coef_expect_q.push_back('{pos: 6'(i), value: coef_store[i], last: (i == NUM_COEF - 1)});
      coef_store[i] = '0;
    end
    zz_idx = 0;
  endtask

  // quant table entry that a word would read, -1 for none
  function automatic int qtab_entry_read(input logic cmd, input logic [15:0] word);
    int k;
    if (cmd == CMD_LOAD || word == PAD_WORD) return -1;
    if (zz_idx == 0) return 0;
    k = zz_idx + int'(word[15:10]);
    return (k < NUM_COEF) ? k : -1;
  endfunction

  // predictor update for one accepted item
  task automatic decode_item(input logic cmd, input logic [5:0] idx, input logic [7:0] val,
                             input logic [15:0] word, input logic typed, input coef_t typed_val);
    int    lvl;
    int    q;
    int    prod;
    coef_t v;
    if (cmd == CMD_LOAD) begin
      qtab[idx] = val;
      qtab_written[idx] = 1'b1;
      return;
    end
    lvl = int'($signed(word[9:0]));
    // first word of a block: scale and dc
    if (zz_idx == 0) begin
      if (word == PAD_WORD) return;
      blk_scale = word[15:10];
      q = int'(qtab[0]);
      v = typed ? typed_val : dequant_coef(lvl, q, lvl * q);
      coef_store[ZZ_TO_RASTER[0]] = v;
      zz_idx = 1;
      return;
    end
    if (word == PAD_WORD) begin
      emit_block();
      return;
    end
    // skip the zero run, then place the level
    zz_idx += int'(word[15:10]);
    if (zz_idx >= NUM_COEF) begin
      emit_block();
      return;
    end
    q = int'(blk_scale) * int'(qtab[zz_idx]);
    prod = (lvl * q) >>> 3;
    v = typed ? typed_val : dequant_coef(lvl, q, prod);
    coef_store[ZZ_TO_RASTER[zz_idx]] = v;
    zz_idx++;
    if (zz_idx >= NUM_COEF) emit_block();
  endtask

  // drive one item, wait for it to be taken, then pace the sender
  task automatic drive_one(input logic cmd, input logic [5:0] idx, input logic [7:0] val,
                           input logic [15:0] word, input logic typed, input coef_t typed_val);
    start         <= 1'b1;
    command_i     <= cmd;
    table_index_i <= idx;
    table_value_i <= val;
    rle_word_i    <= word;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    decode_item(cmd, idx, val, word, typed, typed_val);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    end
  endtask

  // words never read a quant entry that was not loaded yet
  task automatic issue_item(input logic cmd, input logic [5:0] idx, input logic [7:0] val,
                            input logic [15:0] word, input logic typed, input coef_t typed_val);
    int ent;
    ent = qtab_entry_read(cmd, word);
    if (ent >= 0 && !qtab_written[ent])
      drive_one(CMD_LOAD, 6'(ent), 8'($urandom), 16'($urandom), 1'b0, '0);
    drive_one(cmd, idx, val, word, typed, typed_val);
  endtask

  // result checker
  always @(posedge clk_i) begin
    coef_result_t exp_res;
    if (rst_ni && result_valid_o) begin
      if (coef_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected coefficient at position %0d", coeff_position_o));
      end else begin
        exp_res = coef_expect_q.pop_front();
        if (coeff_position_o !== exp_res.pos)
          report_mismatch($sformatf("position %0d, expected %0d", coeff_position_o, exp_res.pos));
        if (coeff_value_o !== exp_res.value)
          report_mismatch($sformatf("value %0d at position %0d, expected %0d",
                                    coeff_value_o, exp_res.pos, exp_res.value));
        if (block_last_o !== exp_res.last)
          report_mismatch($sformatf("block_last %0b at position %0d, expected %0b",
                                    block_last_o, exp_res.pos, exp_res.last));
      end
    end
  end

  // stimulus
  initial begin
    logic        cmd;
    logic [5:0]  idx;
    logic [7:0]  val;
    logic [15:0] word;
    int          roll;
    mismatch_count = 0;
    burst_left     = 0;
    zz_idx         = 0;
    blk_scale      = '0;
    for (int i = 0; i < NUM_COEF; i++) begin
      qtab[i]         = '0;
      qtab_written[i] = 1'b0;
      coef_store[i]   = '0;
    end
    rst_ni        = 1'b0;
    start         = 1'b0;
    command_i     = CMD_LOAD;
    table_index_i = '0;
    table_value_i = '0;
    rle_word_i    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    foreach (DIRECTED_ROWS[r])
      issue_item(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].val,
                 DIRECTED_ROWS[r].word, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].typed_val);

    // random blocks: mostly well-formed words with short runs, some loads and padding
    for (int n = 0; n < NUM_RANDOM; n++) begin
      cmd  = CMD_WORD;
      idx  = 6'($urandom);
      val  = 8'($urandom);
      word = 16'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        cmd = CMD_LOAD;
      end else if (zz_idx == 0) begin
        if (roll < 15) word = PAD_WORD;
      end else if (roll < 14) begin
        word = PAD_WORD;
      end else if (roll < 80) begin
        word[15:10] = 6'($urandom_range(0, 3));
      end else if (roll < 95) begin
        word[15:10] = 6'($urandom_range(4, 20));
      end else begin
        word[15:10] = 6'($urandom_range(21, 63));
      end
      issue_item(cmd, idx, val, word, 1'b0, '0);
    end

    // drain
    start <= 1'b0;
    while (coef_expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && coef_expect_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
